[hw/rtl/wtth_pkg.sv]
// Shared types and constants for the window table with topmost hit test.
package wtth_pkg;

  localparam int unsigned MaxWindowsDefault     = 16;
  localparam int unsigned MaxDisplaySizeDefault = 8192;
  localparam int unsigned DimW                  = 14;
  localparam int unsigned PosW                  = 13;

  localparam logic [13:0] DisplayWidthReset  = 14'd1024;
  localparam logic [13:0] DisplayHeightReset = 14'd768;
  localparam logic [31:0] BackgroundReset    = 32'h0010_1010;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_MOVE    = 2'd1,
    OP_DESTROY = 2'd2,
    OP_SAMPLE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_WIDTH  = 2'd0,
    REG_DISPLAY_HEIGHT = 2'd1,
    REG_BACKGROUND     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] target_id;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] req_width;
    logic [31:0] req_height;
  } in_item_t;

  typedef struct packed {
    logic        success;
    logic [31:0] result_id;
    logic [13:0] granted_width;
    logic [13:0] granted_height;
    logic [3:0]  hit_slot;
    logic [25:0] pixel_offset;
    logic [31:0] fill_color;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic        load;
    logic        move;
    logic        shift;
    logic [31:0] px;
    logic [31:0] py;
    logic [12:0] new_x;
    logic [12:0] new_y;
  } cell_cmd_t;

endpackage

[hw/rtl/window_table_topmost_hit.sv]
// Top level of the window table with topmost hit test.
// One beat is accepted at a time and goes through the steps below, the last held while the output stalls:
// taking the beat in (idle), every slot cell comparing the point and forming its offset
// while the table is updated (scan), and handing the result on (done); the cells work in parallel and a
// destroy closes the gap by each cell taking its upper neighbour's entry.
module window_table_topmost_hit #(
  parameter int unsigned MAX_WINDOWS      = wtth_pkg::MaxWindowsDefault,
  parameter int unsigned MAX_DISPLAY_SIZE = wtth_pkg::MaxDisplaySizeDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wtth_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wtth_pkg::out_item_t   out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import wtth_pkg::*;

  localparam int unsigned SlotW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WINDOWS + 1);

  logic [13:0] display_width;
  logic [13:0] display_height;
  logic [31:0] background_color;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width    <= DisplayWidthReset;
      display_height   <= DisplayHeightReset;
      background_color <= BackgroundReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_DISPLAY_WIDTH:  display_width    <= pwdata[13:0];
        REG_DISPLAY_HEIGHT: display_height   <= pwdata[13:0];
        REG_BACKGROUND:     background_color <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DISPLAY_WIDTH:  prdata = {18'd0, display_width};
      REG_DISPLAY_HEIGHT: prdata = {18'd0, display_height};
      REG_BACKGROUND:     prdata = background_color;
      default:            prdata = 32'd0;
    endcase
  end

  state_t      state;
  state_t      state_next;
  in_item_t    item;
  logic [CntW-1:0] entry_count;
  logic [31:0] next_id;
  out_item_t   result;
  out_item_t   result_next;

  logic [13:0] dw;
  logic [13:0] dh;
  assign dw = ({18'd0, display_width} > 32'(MAX_DISPLAY_SIZE)) ?
              14'(MAX_DISPLAY_SIZE) : display_width;
  assign dh = ({18'd0, display_height} > 32'(MAX_DISPLAY_SIZE)) ?
              14'(MAX_DISPLAY_SIZE) : display_height;

  logic [13:0] cw;
  logic [13:0] ch;
  logic [12:0] cx;
  logic [12:0] cy;
  logic [13:0] limx;
  logic [13:0] limy;
  always_comb begin
    cw   = (item.req_width  > {18'd0, dw}) ? dw : item.req_width[13:0];
    ch   = (item.req_height > {18'd0, dh}) ? dh : item.req_height[13:0];
    limx = (dw == 14'd0) ? 14'd0 : dw - 14'd1;
    limy = (dh == 14'd0) ? 14'd0 : dh - 14'd1;
    cx   = (item.pos_x > {18'd0, limx}) ? limx[12:0] : item.pos_x[12:0];
    cy   = (item.pos_y > {18'd0, limy}) ? limy[12:0] : item.pos_y[12:0];
  end

  entry_t      entries [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] covers;
  logic [MAX_WINDOWS-1:0] id_match;
  logic [25:0] offsets [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] sel;
  logic [MAX_WINDOWS-1:0] shift_in;
  cell_cmd_t   cmd;
  entry_t      new_entry;

  // Oldest matching id and newest covering slot.
  logic             found;
  logic [SlotW-1:0] found_slot;
  logic             hit;
  logic [SlotW-1:0] hit_slot;
  always_comb begin
    found      = 1'b0;
    found_slot = '0;
    hit        = 1'b0;
    hit_slot   = '0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (id_match[i] && (CntW'(i) < entry_count)) begin
        found      = 1'b1;
        found_slot = SlotW'(i);
      end
    end
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      if (covers[i] && (CntW'(i) < entry_count)) begin
        hit      = 1'b1;
        hit_slot = SlotW'(i);
      end
    end
  end

  logic create_ok;
  assign create_ok = (cw != 14'd0) && (ch != 14'd0) && (entry_count < CntW'(MAX_WINDOWS));

  always_comb begin
    new_entry.id = next_id;
    new_entry.x  = cx;
    new_entry.y  = cy;
    new_entry.w  = cw;
    new_entry.h  = ch;
    cmd.px    = item.pos_x;
    cmd.py    = item.pos_y;
    cmd.new_x = cx;
    cmd.new_y = cy;
    cmd.load  = (state == ST_SCAN) && (opcode_t'(item.opcode) == OP_CREATE) && create_ok;
    cmd.move  = (state == ST_SCAN) && (opcode_t'(item.opcode) == OP_MOVE) && found;
    cmd.shift = (state == ST_SCAN) && (opcode_t'(item.opcode) == OP_DESTROY) && found;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      sel[i]      = cmd.load ? (CntW'(i) == entry_count) : (SlotW'(i) == found_slot);
      shift_in[i] = (SlotW'(i) >= found_slot);
      id_match[i] = (entries[i].id == item.target_id);
    end
  end

  for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_cell
    wtth_cell u_cell (
      .clk        (clk),
      .sel        (sel[g]),
      .shift_in   (shift_in[g]),
      .load_entry (new_entry),
      .neighbour  (entries[(g + 1) % MAX_WINDOWS]),
      .cmd        (cmd),
      .entry      (entries[g]),
      .covers     (covers[g]),
      .offset     (offsets[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid)    state_next = ST_SCAN;
      ST_SCAN:                  state_next = ST_DONE;
      ST_DONE: if (!out_stall)  state_next = ST_IDLE;
      default:                  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    out_data  = result;
  end

  always_comb begin
    result_next = '0;
    unique case (opcode_t'(item.opcode))
      OP_CREATE: if (create_ok) begin
        result_next.success        = 1'b1;
        result_next.result_id      = next_id;
        result_next.granted_width  = cw;
        result_next.granted_height = ch;
      end
      OP_MOVE, OP_DESTROY: result_next.success = found;
      OP_SAMPLE: if (hit) begin
        result_next.success      = 1'b1;
        result_next.result_id    = entries[hit_slot].id;
        result_next.hit_slot     = 4'(hit_slot);
        result_next.pixel_offset = offsets[hit_slot];
      end else begin
        result_next.fill_color = background_color;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      next_id     <= 32'd1;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        entry_count <= entry_count + 1'b1;
        next_id     <= next_id + 32'd1;
      end else if (cmd.shift) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_data;
    end
    if (state == ST_SCAN) begin
      result <= result_next;
    end
  end

endmodule

[hw/rtl/wtth_cell.sv]
// One table slot: holds an entry, tests it against the point and hands the offset on.
module wtth_cell (
  input  logic             clk,
  input  logic             sel,
  input  logic             shift_in,
  input  wtth_pkg::entry_t load_entry,
  input  wtth_pkg::entry_t neighbour,
  input  wtth_pkg::cell_cmd_t cmd,
  output wtth_pkg::entry_t entry,
  output logic             covers,
  output logic [25:0]      offset
);

  import wtth_pkg::*;

  entry_t      store;
  logic [13:0] dx;
  logic [13:0] dy;
  logic [25:0] prod;

  always_ff @(posedge clk) begin
    if (cmd.load && sel) begin
      store <= load_entry;
    end else if (cmd.move && sel) begin
      store.x <= cmd.new_x;
      store.y <= cmd.new_y;
    end else if (cmd.shift && shift_in) begin
      store <= neighbour;
    end
  end

  always_comb begin
    covers = ({1'b0, cmd.px} >= {20'd0, store.x})
          && ({1'b0, cmd.py} >= {20'd0, store.y})
          && ({1'b0, cmd.px} < ({20'd0, store.x} + {19'd0, store.w}))
          && ({1'b0, cmd.py} < ({20'd0, store.y} + {19'd0, store.h}));
    dx   = cmd.px[13:0] - {1'b0, store.x};
    dy   = cmd.py[13:0] - {1'b0, store.y};
    prod = {12'd0, dy} * {12'd0, store.w};
  end

  assign offset = prod + {12'd0, dx};
  assign entry  = store;

endmodule

[bench/tb.sv]
// Self-checking testbench for the window table with topmost hit test.
module tb;
  import wtth_pkg::*;

  class window_scoreboard;
    logic [31:0] ids[16];
    logic [12:0] xs[16];
    logic [12:0] ys[16];
    logic [13:0] ws[16];
    logic [13:0] hs[16];
    int unsigned count;
    logic [31:0] next_id;
    logic [13:0] disp_w;
    logic [13:0] disp_h;
    logic [31:0] bg;
    out_item_t pending[$];
    int errors;

    function new();
      count = 0;
      next_id = 1;
      disp_w = DisplayWidthReset;
      disp_h = DisplayHeightReset;
      bg = BackgroundReset;
      errors = 0;
    endfunction

    function logic [12:0] clamp_pos(logic [31:0] req, logic [13:0] dim);
      logic [31:0] lim;
      lim = (dim == 0) ? 32'd0 : {18'd0, dim} - 32'd1;
      return (req > lim) ? lim[12:0] : req[12:0];
    endfunction

    function int find_slot(logic [31:0] id);
      for (int i = 0; i < count; i++) if (ids[i] == id) return i;
      return -1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [13:0] dw;
      logic [13:0] dh;
      logic [31:0] w;
      logic [31:0] h;
      logic [63:0] off;
      int s;
      r = '0;
      dw = (disp_w > 8192) ? 14'd8192 : disp_w;
      dh = (disp_h > 8192) ? 14'd8192 : disp_h;
      case (opcode_t'(it.opcode))
        OP_CREATE: begin
          w = (it.req_width > dw) ? {18'd0, dw} : it.req_width;
          h = (it.req_height > dh) ? {18'd0, dh} : it.req_height;
          if (w != 0 && h != 0 && count < 16) begin
            ids[count] = next_id;
            xs[count] = clamp_pos(it.pos_x, dw);
            ys[count] = clamp_pos(it.pos_y, dh);
            ws[count] = w[13:0];
            hs[count] = h[13:0];
            count++;
            r.success = 1;
            r.result_id = next_id;
            r.granted_width = w[13:0];
            r.granted_height = h[13:0];
            next_id++;
          end
        end
        OP_MOVE: begin
          s = find_slot(it.target_id);
          if (s >= 0) begin
            xs[s] = clamp_pos(it.pos_x, dw);
            ys[s] = clamp_pos(it.pos_y, dh);
            r.success = 1;
          end
        end
        OP_DESTROY: begin
          s = find_slot(it.target_id);
          if (s >= 0) begin
            for (int i = s; i + 1 < count; i++) begin
              ids[i] = ids[i+1];
              xs[i] = xs[i+1];
              ys[i] = ys[i+1];
              ws[i] = ws[i+1];
              hs[i] = hs[i+1];
            end
            count--;
            r.success = 1;
          end
        end
        default: begin
          for (int i = count - 1; i >= 0 && !r.success; i--) begin
            if (it.pos_x >= xs[i] && it.pos_y >= ys[i] &&
                {32'd0, it.pos_x} < {51'd0, xs[i]} + {50'd0, ws[i]} &&
                {32'd0, it.pos_y} < {51'd0, ys[i]} + {50'd0, hs[i]}) begin
              off = (it.pos_y - ys[i]) * ws[i] + (it.pos_x - xs[i]);
              r.success = 1;
              r.result_id = ids[i];
              r.hit_slot = i[3:0];
              r.pixel_offset = off[25:0];
            end
          end
          if (!r.success) r.fill_color = bg;
        end
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.success !== e.success)
        $display("%0t success: expected %h actual %h", $time, e.success, got.success);
      if (got.result_id !== e.result_id)
        $display("%0t result_id: expected %h actual %h", $time, e.result_id, got.result_id);
      if (got.granted_width !== e.granted_width)
        $display("%0t granted_width: expected %h actual %h", $time,
                 e.granted_width, got.granted_width);
      if (got.granted_height !== e.granted_height)
        $display("%0t granted_height: expected %h actual %h", $time,
                 e.granted_height, got.granted_height);
      if (got.hit_slot !== e.hit_slot)
        $display("%0t hit_slot: expected %h actual %h", $time, e.hit_slot, got.hit_slot);
      if (got.pixel_offset !== e.pixel_offset)
        $display("%0t pixel_offset: expected %h actual %h", $time,
                 e.pixel_offset, got.pixel_offset);
      if (got.fill_color !== e.fill_color)
        $display("%0t fill_color: expected %h actual %h", $time, e.fill_color, got.fill_color);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  window_table_topmost_hit i_dut (.*);

  always #1 clk = ~clk;

  window_scoreboard board = new();
  bit quiet_tail = 0;
  bit long_hold = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stalls in bursts, or for a long stretch on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        out_stall <= 0;
        long_hold = 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send(in_item_t it);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_DISPLAY_WIDTH: board.disp_w = value[13:0];
      REG_DISPLAY_HEIGHT: board.disp_h = value[13:0];
      default: board.bg = value;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(0, 1100);
    endcase
  endfunction

  function automatic in_item_t make_item();
    in_item_t it;
    int k;
    it.opcode = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) it.opcode = OP_SAMPLE;
    k = $urandom_range(0, 9);
    if (board.count > 0 && k < 8) it.target_id = board.ids[$urandom_range(0, board.count - 1)];
    else if (k == 8) it.target_id = $urandom();
    else it.target_id = board.next_id - $urandom_range(0, 3);
    it.pos_x = pick_coord();
    it.pos_y = pick_coord();
    it.req_width = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 400);
    it.req_height = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 400);
    return it;
  endfunction

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) send(make_item());
  endtask

  task automatic directed();
    in_item_t it;
    it = '0;
    it.opcode = OP_SAMPLE;
    send(it);
    it.opcode = OP_MOVE; it.target_id = 1;
    send(it);
    it.opcode = OP_DESTROY;
    send(it);
    it.opcode = OP_CREATE; it.req_width = 0; it.req_height = 5;
    send(it);
    it.req_width = 32'hFFFF_FFFF; it.req_height = 32'hFFFF_FFFF;
    it.pos_x = 32'hFFFF_FFFF; it.pos_y = 32'hFFFF_FFFF;
    send(it);
    for (int i = 0; i < 16; i++) begin
      it.opcode = OP_CREATE; it.pos_x = i * 7; it.pos_y = i * 5;
      it.req_width = 10 + i; it.req_height = 8 + i;
      send(it);
    end
    it.opcode = OP_SAMPLE; it.pos_x = 1023; it.pos_y = 767;
    send(it);
    it.pos_x = 110; it.pos_y = 80;
    send(it);
    it.opcode = OP_DESTROY; it.target_id = 2;
    send(it);
    it.opcode = OP_MOVE; it.target_id = 5; it.pos_x = 32'hAAAA_5555; it.pos_y = 32'h5555_AAAA;
    send(it);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    drain();
    write_reg(REG_BACKGROUND, 32'hFFFF_FFFF);
    random_phase(300);
    drain();
    write_reg(REG_DISPLAY_WIDTH, 32'h3FFF);
    write_reg(REG_DISPLAY_HEIGHT, 32'h2001);
    write_reg(REG_BACKGROUND, 32'h0);
    long_hold = 1;
    random_phase(300);
    drain();
    write_reg(REG_DISPLAY_WIDTH, 32'd0);
    write_reg(REG_DISPLAY_HEIGHT, 32'd0);
    random_phase(100);
    drain();
    write_reg(REG_DISPLAY_WIDTH, 32'd1);
    write_reg(REG_DISPLAY_HEIGHT, 32'd1);
    write_reg(REG_BACKGROUND, $urandom());
    random_phase(150);
    drain();
    write_reg(REG_DISPLAY_WIDTH, 32'd8192);
    write_reg(REG_DISPLAY_HEIGHT, 32'd8192);
    random_phase(250);
    drain();
    write_reg(REG_DISPLAY_WIDTH, 32'd64);
    write_reg(REG_DISPLAY_HEIGHT, 32'd48);
    random_phase(350);
    drain();
    write_reg(REG_DISPLAY_WIDTH, {18'd0, DisplayWidthReset});
    write_reg(REG_DISPLAY_HEIGHT, {18'd0, DisplayHeightReset});
    random_phase(150);
    quiet_tail = 1;
    random_phase(100);
    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/wtth_pkg.sv
hw/rtl/wtth_cell.sv
hw/rtl/window_table_topmost_hit.sv
bench/tb.sv
